@@ design/dmi_pkg.sv @@
// Shared types and constants for the directional movement index stream.
`timescale 1ns / 1ps
package dmi_pkg;

    localparam int PERIOD_MAX = 64;
    localparam logic [6:0] PERIOD_RESET = 7'd14;
    localparam logic [22:0] DI_FULL = 23'd6553600;
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // divider request and response between the sequencer and the shared divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [39:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;

    // divisions of one candle, in issue order
    typedef enum logic [2:0] {
        OP_TR  = 3'd0,
        OP_PM  = 3'd1,
        OP_MM  = 3'd2,
        OP_PDI = 3'd3,
        OP_MDI = 3'd4,
        OP_DX  = 3'd5,
        OP_ADX = 3'd6
    } t_op;

endpackage

@@ design/dmi_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 40-bit divisor.
`timescale 1ns / 1ps
module dmi_div import dmi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [63:0]          r_dvd;
    logic [39:0]          r_dvs;
    logic [39:0]          r_rem;
    logic [40:0]          trial;
    logic                 fits;

    assign trial = {r_rem, r_dvd[63]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                // quotient bits shift into the low end as dividend bits leave the top
                r_rem <= fits ? 40'(trial - {1'b0, r_dvs}) : trial[39:0];
                r_dvd <= {r_dvd[62:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd;

endmodule

@@ design/directional_movement_index_stream.sv @@
// Top level: Wilder +DI, -DI and ADX over a candle stream, one shared divider.
//
//  channel   dir   handshake             payload
//  s_axis    in    tvalid/tready         tdata: high, low, close; tuser: series_start
//  m_axis    out   tvalid/tready         tdata: plus_di, minus_di, adx; tuser: di_valid, adx_valid
//  cfg       in    i_cfg_wr_en           i_cfg_wr_data: smoothing_period
//
// A warm-up candle needs no division. A smoothed candle runs seven divisions
// on the shared divider (six when the ADX is still summing).
// Reset is synchronous and active low; it clears history and sets the period to 14.
// s_axis_tready is high only while idle; a result waits in the output register
// if m_axis_tready is low, and the block stalls until it is taken.
`timescale 1ns / 1ps
module directional_movement_index_stream import dmi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // high_price, low_price, close_price
    input  logic        s_axis_tuser,   // series_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // plus_di, minus_di, adx_value, zero pad
    output logic [1:0]  m_axis_tuser,   // di_valid, adx_valid
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CALC   = 5'b00010,
        ST_LAUNCH = 5'b00100,
        ST_WAIT   = 5'b01000,
        ST_OUT    = 5'b10000
    } t_state;

    t_state      r_state;
    t_op         r_op;
    logic [6:0]  r_period;
    logic [31:0] r_h, r_l, r_c;
    logic        r_start;
    logic [31:0] r_ph, r_pl, r_pc;
    logic [7:0]  r_cnt;
    logic [39:0] r_str, r_spm, r_smm;
    logic [31:0] r_x_tr, r_x_pm, r_x_mm;
    logic [22:0] r_pdi, r_mdi, r_dx;
    logic [31:0] r_acc;
    logic        r_out_valid;
    logic [71:0] r_out_data;
    logic [1:0]  r_out_user;

    t_div_req div_req;
    t_div_rsp div_rsp;

    dmi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // period clamped to 2..PERIOD_MAX
    logic [6:0] p;
    always_comb begin
        p = r_period;
        if (r_period < 7'd2) p = 7'd2;
        if (r_period > 7'(PERIOD_MAX)) p = 7'(PERIOD_MAX);
    end

    // candle differences
    logic signed [32:0] hd, ld, hl, hpc, lpc, trv;
    logic [31:0] tr32, pdm, mdm;
    logic [7:0]  base_cnt, cnt_next, i_idx;
    logic        warm;
    always_comb begin
        hd  = $signed({1'b0, r_h}) - $signed({1'b0, r_ph});
        ld  = $signed({1'b0, r_pl}) - $signed({1'b0, r_l});
        hl  = $signed({1'b0, r_h}) - $signed({1'b0, r_l});
        hpc = $signed({1'b0, r_h}) - $signed({1'b0, r_pc});
        lpc = $signed({1'b0, r_l}) - $signed({1'b0, r_pc});
        if (hpc < 0) hpc = -hpc;
        if (lpc < 0) lpc = -lpc;
        trv = hl;
        if (hpc > trv) trv = hpc;
        if (lpc > trv) trv = lpc;
        tr32 = trv[31:0];
        pdm  = (hd > ld && hd > 0) ? hd[31:0] : 32'd0;
        mdm  = (ld > hd && ld > 0) ? ld[31:0] : 32'd0;
        base_cnt = r_start ? 8'd0 : r_cnt;
        cnt_next = (base_cnt == 8'd255) ? base_cnt : base_cnt + 8'd1;
        i_idx    = cnt_next - 8'd1;
        warm     = i_idx <= {1'b0, p};
    end

    function automatic logic [39:0] sat_add40(input logic [39:0] s, input logic [31:0] x);
        logic [40:0] t;
        t = {1'b0, s} + {9'b0, x};
        return t[40] ? '1 : t[39:0];
    endfunction

    function automatic logic [39:0] wilder40(input logic [39:0] s, input logic [39:0] q,
                                            input logic [31:0] x);
        logic [41:0] t;
        t = {2'b0, s} - {2'b0, q} + {10'b0, x};
        return (t[41:40] != 2'b00) ? '1 : t[39:0];
    endfunction

    function automatic logic [22:0] ratio_clamp(input logic [63:0] q, input logic den_zero);
        if (den_zero) return '0;
        return (q > {41'b0, DI_FULL}) ? DI_FULL : q[22:0];
    endfunction

    function automatic logic [31:0] acc_add_next(input logic [31:0] a, input logic [22:0] d);
        logic [32:0] t;
        t = {1'b0, a} + {10'b0, d};
        return t[32] ? '1 : t[31:0];
    endfunction

    // ADX phase: k counts DX values so far, this one included
    logic [7:0]  k;
    logic [22:0] di_diff;
    logic [23:0] di_sum;
    logic [32:0] acc_add;
    logic [31:0] acc_sat;
    logic [22:0] acc_min;
    logic [30:0] adx_num;
    logic [46:0] pm_scaled, mm_scaled;
    logic [29:0] dx_scaled;
    logic [39:0] p40;
    always_comb begin
        k        = r_cnt - {1'b0, p} - 8'd1;
        di_diff  = (r_pdi > r_mdi) ? r_pdi - r_mdi : r_mdi - r_pdi;
        di_sum   = {1'b0, r_pdi} + {1'b0, r_mdi};
        acc_add  = {1'b0, r_acc} + {10'b0, r_dx};
        acc_sat  = acc_add[32] ? '1 : acc_add[31:0];
        acc_min  = (r_acc > {9'b0, DI_FULL}) ? DI_FULL : r_acc[22:0];
        adx_num  = 31'({7'b0, acc_min} * {23'b0, p - 7'd1}) + {8'b0, r_dx};
        pm_scaled = {7'b0, r_spm} * 47'd100;
        mm_scaled = {7'b0, r_smm} * 47'd100;
        dx_scaled = {7'b0, di_diff} * 30'd100;
        p40       = {33'b0, p};
    end

    always_comb begin
        div_req.start = (r_state == ST_LAUNCH);
        case (r_op)
            OP_TR:   begin div_req.dividend = {24'b0, r_str}; div_req.divisor = p40; end
            OP_PM:   begin div_req.dividend = {24'b0, r_spm}; div_req.divisor = p40; end
            OP_MM:   begin div_req.dividend = {24'b0, r_smm}; div_req.divisor = p40; end
            OP_PDI:  begin div_req.dividend = {1'b0, pm_scaled, 16'b0}; div_req.divisor = r_str; end
            OP_MDI:  begin div_req.dividend = {1'b0, mm_scaled, 16'b0}; div_req.divisor = r_str; end
            OP_DX:   begin
                div_req.dividend = {18'b0, dx_scaled, 16'b0};
                div_req.divisor  = {16'b0, di_sum};
            end
            OP_ADX:  begin
                div_req.dividend = (k == {1'b0, p}) ? {32'b0, acc_sat} : {33'b0, adx_num};
                div_req.divisor  = p40;
            end
            default: begin div_req.dividend = '0; div_req.divisor = p40; end
        endcase
    end

    logic       di_ok, adx_ok;
    logic [22:0] adx_out;
    always_comb begin
        di_ok   = r_cnt >= {p, 1'b0};
        adx_ok  = (r_cnt > {1'b0, p}) && (k >= {1'b0, p});
        adx_out = (r_acc > {9'b0, DI_FULL}) ? DI_FULL : r_acc[22:0];
    end

    logic [63:0] q;
    assign q = div_rsp.quotient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_TR;
            r_period    <= PERIOD_RESET;
            r_ph        <= '0;
            r_pl        <= '0;
            r_pc        <= '0;
            r_cnt       <= '0;
            r_str       <= '0;
            r_spm       <= '0;
            r_smm       <= '0;
            r_acc       <= '0;
            r_pdi       <= '0;
            r_mdi       <= '0;
            r_dx        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_period <= i_cfg_wr_data;
            // in ST_OUT the output register is reloaded below instead
            if (r_out_valid && m_axis_tready && r_state != ST_OUT) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_h     <= s_axis_tdata[31:0];
                        r_l     <= s_axis_tdata[63:32];
                        r_c     <= s_axis_tdata[95:64];
                        r_start <= s_axis_tuser;
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    r_ph  <= r_h;
                    r_pl  <= r_l;
                    r_pc  <= r_c;
                    r_cnt <= cnt_next;
                    r_pdi <= '0;
                    r_mdi <= '0;
                    if (r_start) r_acc <= '0;
                    if (base_cnt == 8'd0) begin
                        if (r_start) begin
                            r_str <= '0;
                            r_spm <= '0;
                            r_smm <= '0;
                        end
                        r_state <= ST_OUT;
                    end else if (warm) begin
                        r_str   <= sat_add40(r_str, tr32);
                        r_spm   <= sat_add40(r_spm, pdm);
                        r_smm   <= sat_add40(r_smm, mdm);
                        r_state <= ST_OUT;
                    end else begin
                        r_x_tr  <= tr32;
                        r_x_pm  <= pdm;
                        r_x_mm  <= mdm;
                        r_op    <= OP_TR;
                        r_state <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (div_rsp.done) begin
                        r_state <= ST_LAUNCH;
                        case (r_op)
                            OP_TR:  begin r_str <= wilder40(r_str, q[39:0], r_x_tr); r_op <= OP_PM; end
                            OP_PM:  begin r_spm <= wilder40(r_spm, q[39:0], r_x_pm); r_op <= OP_MM; end
                            OP_MM:  begin r_smm <= wilder40(r_smm, q[39:0], r_x_mm); r_op <= OP_PDI; end
                            OP_PDI: begin r_pdi <= ratio_clamp(q, r_str == '0); r_op <= OP_MDI; end
                            OP_MDI: begin r_mdi <= ratio_clamp(q, r_str == '0); r_op <= OP_DX; end
                            OP_DX:  begin
                                r_dx <= ratio_clamp(q, di_sum == '0);
                                r_op <= OP_ADX;
                                // still summing DX: no division needed
                                if (k < {1'b0, p}) begin
                                    r_acc   <= acc_add_next(r_acc, ratio_clamp(q, di_sum == '0));
                                    r_state <= ST_OUT;
                                end
                            end
                            OP_ADX: begin
                                r_acc   <= q[31:0];
                                r_state <= ST_OUT;
                            end
                            default: r_state <= ST_OUT;
                        endcase
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {3'b0,
                                        adx_ok ? adx_out : 23'd0,
                                        di_ok ? r_mdi : 23'd0,
                                        di_ok ? r_pdi : 23'd0};
                        r_out_user  <= {adx_ok, di_ok};
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    property p_adx_needs_di;
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0];
    endproperty
    a_adx_needs_di: assert property (p_adx_needs_di)
        else $error("adx_valid without di_valid");

    property p_div_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !div_rsp.busy;
    endproperty
    a_div_idle: assert property (p_div_idle)
        else $error("divider busy while sequencer idle");

    property p_di_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:0] <= DI_FULL) && (m_axis_tdata[45:23] <= DI_FULL);
    endproperty
    a_di_range: assert property (p_di_range)
        else $error("DI out of range");

endmodule
